// ----- src/mcv_pkg.sv -----
// Shared types, widths and helpers of the mesh centroid and volume block.
// No dependencies; every other file imports this package.
package mcv_pkg;

  localparam int FIELD_W       = 12;
  localparam int COORD_BITS    = 12;
  localparam int MAX_TRIANGLES = 1024;
  localparam int FRACTION_BITS = 4;

  localparam int CNT_W   = $clog2(MAX_TRIANGLES + 2);
  localparam int VOL_W   = 47;
  localparam int WSUM_W  = 64;
  localparam int CEN_W   = 17;
  localparam int CEN_MAX     = 65535;
  localparam int CEN_MIN_MAG = 65536;

  // Triple product datapath widths
  localparam int SUM_W   = COORD_BITS + 2;
  localparam int PROD_W  = 2 * COORD_BITS;
  localparam int CROSS_W = PROD_W + 1;
  localparam int TERM_W  = CROSS_W + COORD_BITS;
  localparam int DET_W   = TERM_W + 2;
  localparam int WPROD_W = SUM_W + DET_W;

  // Divider: quotient bits below the overflow bit, plus one rounding bit
  localparam int QB     = CEN_W + FRACTION_BITS + 1;
  localparam int QCNT_W = $clog2(QB + 1);
  localparam int REM_A  = WSUM_W + FRACTION_BITS + 1;
  localparam int REM_B  = VOL_W + 2 + QB;
  localparam int REM_W  = (REM_A > REM_B) ? REM_A : REM_B;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  // One queue entry: a triangle to add, the end of a mesh, or both
  typedef struct packed {
    vec_t a;
    vec_t b;
    vec_t c;
    logic is_tri;
    logic last;
    logic ovf;
  } tri_item_t;

  typedef struct packed {
    logic signed [VOL_W-1:0]  vol;
    logic signed [WSUM_W-1:0] wx;
    logic signed [WSUM_W-1:0] wy;
    logic signed [WSUM_W-1:0] wz;
    logic                     ovf;
  } mesh_sum_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN,
    DIV_HOLD
  } div_state_t;

  function automatic coord_t to_coord(input logic [FIELD_W-1:0] v);
    return coord_t'(v[COORD_BITS-1:0]);
  endfunction

endpackage

// ----- src/mesh_centroid_and_volume.sv -----
// Mesh centroid and signed volume: streams vertices in facet order and gives
// six times the volume and the Q12.4 centroid per mesh.
//
// Input: one vertex per item (push/full). in_facet_start marks a facet's first
// vertex, in_mesh_end the mesh's last vertex. Each facet is fanned from its
// first vertex; every vertex after its second closes a triangle.
// Output: one result per mesh (empty/pop); it stays on the out_ ports until
// popped. centroid_valid is low for a zero volume or after more than
// MAX_TRIANGLES triangles, with the centroid fields zero.
// Throughput: one vertex per cycle inside a mesh while the queue is not full. A
// mesh end passes through the queue and the 4-stage multiply pipeline, then the
// divider (one quotient bit per cycle for 23 bits, plus rounding); vertices of
// the next mesh are taken meanwhile until the 4-entry queue fills.
// The back end takes no item behind a mesh end until that result is popped, so
// a stalled receiver holds the result, the queue fills up and full rises.
// Reset (rst_n low, synchronous) empties the queue, clears the running sums
// and the triangle count and drops any result that was waiting.
// Depends on mcv_pkg, mcv_front, mcv_queue, mcv_accum and mcv_div.
module mesh_centroid_and_volume import mcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  logic signed [11:0]      in_vert_x,
  input  logic signed [11:0]      in_vert_y,
  input  logic signed [11:0]      in_vert_z,
  input  logic                    in_facet_start,
  input  logic                    in_mesh_end,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VOL_W-1:0] out_six_volume,
  output logic signed [CEN_W-1:0] out_centroid_x,
  output logic signed [CEN_W-1:0] out_centroid_y,
  output logic signed [CEN_W-1:0] out_centroid_z,
  output logic                    out_centroid_valid,
  output logic                    out_overflowed
);

  tri_item_t wr_item, rd_item;
  mesh_sum_t sum;
  logic      q_wr, q_rd, q_full, q_empty, div_idle, sum_start;

  mcv_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .vert_x      (in_vert_x),
    .vert_y      (in_vert_y),
    .vert_z      (in_vert_z),
    .facet_start (in_facet_start),
    .mesh_end    (in_mesh_end),
    .q_full      (q_full),
    .q_wr        (q_wr),
    .q_item      (wr_item)
  );

  mcv_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (wr_item),
    .rd      (q_rd),
    .rd_item (rd_item),
    .full    (q_full),
    .empty   (q_empty)
  );

  mcv_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (rd_item),
    .q_rd      (q_rd),
    .div_idle  (div_idle),
    .sum_start (sum_start),
    .sum_out   (sum)
  );

  mcv_div u_div (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (sum_start),
    .sum_in         (sum),
    .idle           (div_idle),
    .empty          (empty),
    .pop            (pop),
    .six_volume     (out_six_volume),
    .centroid_x     (out_centroid_x),
    .centroid_y     (out_centroid_y),
    .centroid_z     (out_centroid_z),
    .centroid_valid (out_centroid_valid),
    .overflowed     (out_overflowed)
  );

endmodule

// ----- src/mcv_front.sv -----
// Front end: accepts vertices, tracks the facet fan and the triangle count,
// and writes triangles and mesh ends into the queue. Depends on mcv_pkg.
module mcv_front import mcv_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [FIELD_W-1:0] vert_x,
  input  logic [FIELD_W-1:0] vert_y,
  input  logic [FIELD_W-1:0] vert_z,
  input  logic               facet_start,
  input  logic               mesh_end,
  input  logic               q_full,
  output logic               q_wr,
  output tri_item_t          q_item
);

  vec_t             anchor_r, anchor_nxt;
  vec_t             prev_r, prev_nxt;
  logic [1:0]       nverts_r, nverts_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_upd;
  vec_t             v;
  logic             accept, tri_kept;

  assign full   = q_full;
  assign accept = push & ~q_full;

  always_comb begin
    v.x = to_coord(vert_x);
    v.y = to_coord(vert_y);
    v.z = to_coord(vert_z);
    anchor_nxt = anchor_r;
    prev_nxt   = prev_r;
    nverts_nxt = nverts_r;
    cnt_upd    = cnt_r;
    tri_kept   = 1'b0;
    if (facet_start || nverts_r == 2'd0) begin
      anchor_nxt = v;
      nverts_nxt = 2'd1;
    end else if (nverts_r == 2'd1) begin
      prev_nxt   = v;
      nverts_nxt = 2'd2;
    end else begin
      prev_nxt = v;
      if (cnt_r >= CNT_W'(MAX_TRIANGLES)) begin
        cnt_upd = CNT_W'(MAX_TRIANGLES + 1);
      end else begin
        cnt_upd  = cnt_r + CNT_W'(1);
        tri_kept = 1'b1;
      end
    end
    cnt_nxt = cnt_upd;
    if (mesh_end) begin
      nverts_nxt = 2'd0;
      cnt_nxt    = '0;
    end
  end

  always_comb begin
    q_item.a      = anchor_r;
    q_item.b      = prev_r;
    q_item.c      = v;
    q_item.is_tri = tri_kept;
    q_item.last   = mesh_end;
    q_item.ovf    = cnt_upd > CNT_W'(MAX_TRIANGLES);
    q_wr          = accept & (tri_kept | mesh_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nverts_r <= '0;
      cnt_r    <= '0;
    end else if (accept) begin
      nverts_r <= nverts_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      anchor_r <= anchor_nxt;
      prev_r   <= prev_nxt;
    end
  end

endmodule

// ----- src/mcv_queue.sv -----
// Short queue of triangle items between the front end and the accumulator.
// Depends on mcv_pkg.
module mcv_queue import mcv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  tri_item_t wr_item,
  input  logic      rd,
  output tri_item_t rd_item,
  output logic      full,
  output logic      empty
);

  tri_item_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full    = cnt_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + QPTR_W'(1);
      if (rd) rp_r <= rp_r + QPTR_W'(1);
      if (wr && !rd)      cnt_r <= cnt_r + (QPTR_W+1)'(1);
      else if (!wr && rd) cnt_r <= cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_item;
  end

endmodule

// ----- src/mcv_accum.sv -----
// Back end: pipelined triple products and the running volume and weighted
// sums; hands the totals to the divider at mesh end. Depends on mcv_pkg.
module mcv_accum import mcv_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  tri_item_t q_item,
  output logic      q_rd,
  input  logic      div_idle,
  output logic      sum_start,
  output mesh_sum_t sum_out
);

  typedef struct packed {
    logic v;
    logic is_tri;
    logic last;
    logic ovf;
  } stage_flags_t;

  stage_flags_t f1_r, f2_r, f3_r, f4_r;

  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  vec_t                      c1_r;
  logic signed [SUM_W-1:0]   s1x_r, s1y_r, s1z_r, s2x_r, s2y_r, s2z_r, s3x_r, s3y_r, s3z_r;
  logic signed [CROSS_W-1:0] crx, cry, crz;
  logic signed [TERM_W-1:0]  mx_r, my_r, mz_r;
  logic signed [DET_W-1:0]   det3_r, det4_r;
  logic signed [WPROD_W-1:0] w4x_r, w4y_r, w4z_r;

  logic signed [VOL_W-1:0]  vol_r, vol_nxt;
  logic signed [WSUM_W-1:0] wx_r, wy_r, wz_r, wx_nxt, wy_nxt, wz_nxt;
  logic                     end_in_flight;

  // No new item enters behind a mesh end until the divider is free again
  assign end_in_flight = (f1_r.v & f1_r.last) | (f2_r.v & f2_r.last) |
                         (f3_r.v & f3_r.last) | (f4_r.v & f4_r.last);
  assign q_rd = ~q_empty & ~end_in_flight & div_idle;

  assign crx = CROSS_W'(p0_r) - CROSS_W'(p1_r);
  assign cry = CROSS_W'(p2_r) - CROSS_W'(p3_r);
  assign crz = CROSS_W'(p4_r) - CROSS_W'(p5_r);

  always_comb begin
    vol_nxt = vol_r;
    wx_nxt  = wx_r;
    wy_nxt  = wy_r;
    wz_nxt  = wz_r;
    if (f4_r.is_tri) begin
      vol_nxt = vol_r + VOL_W'(det4_r);
      wx_nxt  = wx_r + WSUM_W'(w4x_r);
      wy_nxt  = wy_r + WSUM_W'(w4y_r);
      wz_nxt  = wz_r + WSUM_W'(w4z_r);
    end
    sum_start   = f4_r.v & f4_r.last;
    sum_out.vol = vol_nxt;
    sum_out.wx  = wx_nxt;
    sum_out.wy  = wy_nxt;
    sum_out.wz  = wz_nxt;
    sum_out.ovf = f4_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_r  <= '0;
      f2_r  <= '0;
      f3_r  <= '0;
      f4_r  <= '0;
      vol_r <= '0;
      wx_r  <= '0;
      wy_r  <= '0;
      wz_r  <= '0;
    end else begin
      f1_r <= q_rd ? {1'b1, q_item.is_tri, q_item.last, q_item.ovf} : '0;
      f2_r <= f1_r;
      f3_r <= f2_r;
      f4_r <= f3_r;
      if (f4_r.v) begin
        if (f4_r.last) begin
          vol_r <= '0;
          wx_r  <= '0;
          wy_r  <= '0;
          wz_r  <= '0;
        end else begin
          vol_r <= vol_nxt;
          wx_r  <= wx_nxt;
          wy_r  <= wy_nxt;
          wz_r  <= wz_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    p0_r  <= q_item.a.y * q_item.b.z;
    p1_r  <= q_item.a.z * q_item.b.y;
    p2_r  <= q_item.a.z * q_item.b.x;
    p3_r  <= q_item.a.x * q_item.b.z;
    p4_r  <= q_item.a.x * q_item.b.y;
    p5_r  <= q_item.a.y * q_item.b.x;
    c1_r  <= q_item.c;
    s1x_r <= SUM_W'(q_item.a.x) + SUM_W'(q_item.b.x) + SUM_W'(q_item.c.x);
    s1y_r <= SUM_W'(q_item.a.y) + SUM_W'(q_item.b.y) + SUM_W'(q_item.c.y);
    s1z_r <= SUM_W'(q_item.a.z) + SUM_W'(q_item.b.z) + SUM_W'(q_item.c.z);
    mx_r  <= crx * c1_r.x;
    my_r  <= cry * c1_r.y;
    mz_r  <= crz * c1_r.z;
    s2x_r <= s1x_r;
    s2y_r <= s1y_r;
    s2z_r <= s1z_r;
    det3_r <= DET_W'(mx_r) + DET_W'(my_r) + DET_W'(mz_r);
    s3x_r <= s2x_r;
    s3y_r <= s2y_r;
    s3z_r <= s2z_r;
    det4_r <= det3_r;
    w4x_r  <= s3x_r * det3_r;
    w4y_r  <= s3y_r * det3_r;
    w4z_r  <= s3z_r * det3_r;
  end

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sum_start |-> div_idle) else $error("mesh end reached a busy divider");

  a_no_pop_behind_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !end_in_flight) else $error("item popped behind a mesh end");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    sum_start |=> (vol_r == '0 && wx_r == '0 && wy_r == '0 && wz_r == '0))
    else $error("accumulators not cleared after mesh end");

endmodule

// ----- src/mcv_div.sv -----
// Centroid divider and result register: restoring division one quotient bit
// per cycle on three axes at once, rounding and saturation. Depends on mcv_pkg.
module mcv_div import mcv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  mesh_sum_t               sum_in,
  output logic                    idle,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [VOL_W-1:0] six_volume,
  output logic signed [CEN_W-1:0] centroid_x,
  output logic signed [CEN_W-1:0] centroid_y,
  output logic signed [CEN_W-1:0] centroid_z,
  output logic                    centroid_valid,
  output logic                    overflowed
);

  div_state_t        state_r, state_nxt;
  logic [QCNT_W-1:0] cnt_r;
  logic [REM_W-1:0]  rem_r [3];
  logic [QB:0]       q_r [3];
  logic              neg_r [3];
  logic [REM_W-1:0]  dsh_r;
  logic [CEN_W-1:0]  cen_r [3];
  logic [VOL_W-1:0]  vol_r;
  logic              valid_r, ovf_r, start_valid;
  logic [WSUM_W-1:0] w_in [3];
  logic [WSUM_W-1:0] wmag [3];
  logic [VOL_W-1:0]  vmag;

  function automatic logic [CEN_W-1:0] round_sat(input logic [QB:0] q, input logic neg);
    logic [QB-1:0] mag;
    mag = QB'(({1'b0, q[QB-1:0]} + (QB+1)'(1)) >> 1);
    if (neg) begin
      if (q[QB] || mag > QB'(CEN_MIN_MAG)) return CEN_W'(CEN_MIN_MAG);
      return CEN_W'(~mag + QB'(1));
    end
    if (q[QB] || mag > QB'(CEN_MAX)) return CEN_W'(CEN_MAX);
    return CEN_W'(mag);
  endfunction

  assign start_valid = ~sum_in.ovf & (sum_in.vol != '0);
  assign w_in[0] = sum_in.wx;
  assign w_in[1] = sum_in.wy;
  assign w_in[2] = sum_in.wz;
  // magnitudes taken at the sum width, before widening for the remainder
  assign wmag[0] = w_in[0][WSUM_W-1] ? -w_in[0] : w_in[0];
  assign wmag[1] = w_in[1][WSUM_W-1] ? -w_in[1] : w_in[1];
  assign wmag[2] = w_in[2][WSUM_W-1] ? -w_in[2] : w_in[2];
  assign vmag    = sum_in.vol[VOL_W-1] ? VOL_W'(-sum_in.vol) : VOL_W'(sum_in.vol);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DIV_IDLE: if (start) state_nxt = start_valid ? DIV_RUN : DIV_HOLD;
      DIV_RUN:  if (cnt_r == '0) state_nxt = DIV_FIN;
      DIV_FIN:  state_nxt = DIV_HOLD;
      DIV_HOLD: if (pop) state_nxt = DIV_IDLE;
      default:  state_nxt = DIV_IDLE;
    endcase
  end

  always_comb begin
    idle  = 1'b0;
    empty = 1'b1;
    case (state_r)
      DIV_IDLE: idle  = 1'b1;
      DIV_HOLD: empty = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= DIV_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DIV_IDLE: begin
        if (start) begin
          vol_r   <= sum_in.vol;
          ovf_r   <= sum_in.ovf;
          valid_r <= start_valid;
          cnt_r   <= QCNT_W'(QB);
          dsh_r   <= REM_W'({vmag, 2'b00}) << QB;
          for (int i = 0; i < 3; i++) begin
            cen_r[i] <= '0;
            q_r[i]   <= '0;
            neg_r[i] <= w_in[i][WSUM_W-1] ^ sum_in.vol[VOL_W-1];
            rem_r[i] <= REM_W'(wmag[i]) << (FRACTION_BITS + 1);
          end
        end
      end
      DIV_RUN: begin
        for (int i = 0; i < 3; i++) begin
          if (rem_r[i] >= dsh_r) rem_r[i] <= rem_r[i] - dsh_r;
          q_r[i] <= {q_r[i][QB-1:0], rem_r[i] >= dsh_r};
        end
        dsh_r <= dsh_r >> 1;
        cnt_r <= cnt_r - QCNT_W'(1);
      end
      DIV_FIN: begin
        for (int i = 0; i < 3; i++) cen_r[i] <= round_sat(q_r[i], neg_r[i]);
      end
      default: ;
    endcase
  end

  assign six_volume     = vol_r;
  assign centroid_x     = cen_r[0];
  assign centroid_y     = cen_r[1];
  assign centroid_z     = cen_r[2];
  assign centroid_valid = valid_r;
  assign overflowed     = ovf_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIV_HOLD && !valid_r) |->
    (cen_r[0] == '0 && cen_r[1] == '0 && cen_r[2] == '0))
    else $error("invalid centroid not zero");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && state_r == DIV_IDLE) |=> state_r != DIV_IDLE)
    else $error("divider ignored a start");

  a_fin_after_last_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DIV_FIN) |-> ($past(state_r) == DIV_RUN && $past(cnt_r) == '0))
    else $error("division finished early");

endmodule
